/* hw/rtl/tksd_pkg.sv */
package tksd_pkg;

  localparam int unsigned StoreDepth = 5;

  // Byte values of interest
  localparam logic [7:0] BYTE_BS    = 8'h08;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_CR    = 8'h0d;
  localparam logic [7:0] BYTE_ESC   = 8'h1b;
  localparam logic [7:0] BYTE_DEL   = 8'h7f;
  localparam logic [7:0] BYTE_CTRLZ = 8'h1a;
  localparam logic [7:0] BYTE_LBRK  = 8'h5b;
  localparam logic [7:0] BYTE_TILDE = 8'h7e;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;
  localparam logic [7:0] BYTE_NINE  = 8'h39;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_B     = 8'h42;
  localparam logic [7:0] CHAR_C     = 8'h43;
  localparam logic [7:0] CHAR_D     = 8'h44;
  localparam logic [7:0] CHAR_E     = 8'h45;
  localparam logic [7:0] CHAR_F     = 8'h46;
  localparam logic [7:0] CHAR_G     = 8'h47;
  localparam logic [7:0] CHAR_H     = 8'h48;
  localparam logic [7:0] CHAR_1     = 8'h31;
  localparam logic [7:0] CHAR_2     = 8'h32;
  localparam logic [7:0] CHAR_3     = 8'h33;
  localparam logic [7:0] CHAR_4     = 8'h34;
  localparam logic [7:0] CHAR_5     = 8'h35;
  localparam logic [7:0] CHAR_6     = 8'h36;
  localparam logic [20:0] CTRL_OFFSET = 21'h60;

  // Named key codes
  localparam logic [4:0] KEY_BKSP  = 5'd0;
  localparam logic [4:0] KEY_TAB   = 5'd1;
  localparam logic [4:0] KEY_ENTER = 5'd2;
  localparam logic [4:0] KEY_ESC   = 5'd3;
  localparam logic [4:0] KEY_UP    = 5'd4;
  localparam logic [4:0] KEY_DOWN  = 5'd5;
  localparam logic [4:0] KEY_LEFT  = 5'd6;
  localparam logic [4:0] KEY_RIGHT = 5'd7;
  localparam logic [4:0] KEY_INS   = 5'd8;
  localparam logic [4:0] KEY_DEL   = 5'd9;
  localparam logic [4:0] KEY_HOME  = 5'd10;
  localparam logic [4:0] KEY_END   = 5'd11;
  localparam logic [4:0] KEY_PGUP  = 5'd12;
  localparam logic [4:0] KEY_PGDN  = 5'd13;
  localparam logic [4:0] KEY_KP5   = 5'd14;
  localparam logic [4:0] KEY_F1    = 5'd16;

  typedef struct packed {
    logic [StoreDepth-1:0][7:0] bytes;
    logic [2:0]                 n;
  } chunk_t;

  typedef struct packed {
    logic        is_named_key;
    logic [4:0]  key_code;
    logic [20:0] char_code;
    logic        shift;
    logic        alt;
    logic        ctrl;
  } key_t;

  typedef struct packed {
    logic ok;
    key_t key;
  } res_t;

endpackage

/* hw/rtl/tksd_ifs.sv */
interface tksd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_req;
  logic       last;

  modport source (output valid, output byte_req, output last, input ready);
  modport sink (input valid, input byte_req, input last, output ready);
endinterface

interface tksd_out_if;
  logic        valid;
  logic        ready;
  logic        is_named_key;
  logic [4:0]  key_code;
  logic [20:0] char_code;
  logic        shift;
  logic        alt;
  logic        ctrl;

  modport source (output valid, output is_named_key, output key_code, output char_code,
                  output shift, output alt, output ctrl, input ready);
  modport sink (input valid, input is_named_key, input key_code, input char_code,
                input shift, input alt, input ctrl, output ready);
endinterface

/* hw/rtl/tksd_capture.sv */
module tksd_capture (
  input  logic             clk,
  input  logic             rst_n,
  tksd_in_if.sink          in_ch,
  input  logic             chunk_ready,
  output logic             chunk_valid,
  output tksd_pkg::chunk_t chunk
);
  import tksd_pkg::*;

  logic [7:0] store_r [StoreDepth];
  logic [2:0] count_r, count_nxt;
  logic       chunk_valid_r, chunk_valid_nxt;
  chunk_t     chunk_r, chunk_nxt;
  logic       accept;
  logic       full;

  assign full        = (count_r == 3'(StoreDepth));
  assign in_ch.ready = !chunk_valid_r || chunk_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign chunk_valid = chunk_valid_r;
  assign chunk       = chunk_r;

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      if (in_ch.last) begin
        count_nxt = 3'd0;
      end else if (!full) begin
        count_nxt = count_r + 3'd1;
      end
    end
  end

  // The word carrying the end mark is folded into the snapshot directly,
  // so the decoder sees the whole chunk in the cycle after that word is taken.
  always_comb begin
    for (int i = 0; i < StoreDepth; i++) begin
      chunk_nxt.bytes[i] = (count_r == 3'(i)) ? in_ch.byte_req : store_r[i];
    end
    chunk_nxt.n = full ? count_r : count_r + 3'd1;
  end

  always_comb begin
    chunk_valid_nxt = chunk_valid_r && !chunk_ready;
    if (accept && in_ch.last) begin
      chunk_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < StoreDepth; i++) begin
      if (accept && count_r == 3'(i)) begin
        store_r[i] <= in_ch.byte_req;
      end
    end
    if (accept && in_ch.last) begin
      chunk_r <= chunk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= 3'd0;
      chunk_valid_r <= 1'b0;
    end else begin
      count_r       <= count_nxt;
      chunk_valid_r <= chunk_valid_nxt;
    end
  end

endmodule

/* hw/rtl/tksd_decode.sv */
module tksd_decode (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             chunk_valid,
  input  tksd_pkg::chunk_t chunk,
  output logic             chunk_ready,
  tksd_out_if.source       out_ch
);
  import tksd_pkg::*;

  function automatic res_t give_named(input logic [4:0] code, input logic shift_in,
                                      input logic alt_in);
    res_t r;
    r                  = '0;
    r.ok               = 1'b1;
    r.key.is_named_key = 1'b1;
    r.key.key_code     = code;
    r.key.shift        = shift_in;
    r.key.alt          = alt_in;
    return r;
  endfunction

  // Single byte forms, including a UTF-8 sequence that starts at pos.
  function automatic res_t decode_single(input chunk_t ch, input logic pos,
                                         input logic alt_in);
    logic [7:0]  c;
    logic [7:0]  d;
    logic [1:0]  k;
    logic [2:0]  remain;
    logic [2:0]  idx;
    logic [20:0] cp;
    logic        bad;
    res_t        r;
    c      = pos ? ch.bytes[1] : ch.bytes[0];
    k      = 2'd0;
    cp     = 21'(c);
    bad    = 1'b0;
    r      = '0;
    remain = ch.n - 3'(pos) - 3'd1;
    case (c)
      BYTE_BS, BYTE_DEL: r = give_named(KEY_BKSP, 1'b0, alt_in);
      BYTE_TAB:          r = give_named(KEY_TAB, 1'b0, alt_in);
      BYTE_CR:           r = give_named(KEY_ENTER, 1'b0, alt_in);
      BYTE_ESC:          r = give_named(KEY_ESC, 1'b0, alt_in);
      default: begin
        if (c != 8'h00 && c <= BYTE_CTRLZ) begin
          r.key.char_code = 21'(c) + CTRL_OFFSET;
          r.key.ctrl      = 1'b1;
        end else if (c[7]) begin
          if (c[7:5] == 3'b110) begin
            k  = 2'd1;
            cp = 21'(c[4:0]);
          end else if (c[7:4] == 4'b1110) begin
            k  = 2'd2;
            cp = 21'(c[3:0]);
          end else if (c[7:3] == 5'b11110) begin
            k  = 2'd3;
            cp = 21'(c[2:0]);
          end else begin
            bad = 1'b1;
          end
          if (remain < {1'b0, k}) begin
            bad = 1'b1;
          end
          for (int i = 1; i <= 3; i++) begin
            idx = 3'(pos) + 3'(i);
            d   = ch.bytes[idx];
            if (2'(i) <= k) begin
              if (d[7:6] != 2'b10) begin
                bad = 1'b1;
              end
              cp = {cp[14:0], d[5:0]};
            end
          end
          r.key.char_code = cp;
        end else begin
          r.key.char_code = cp;
        end
        r.key.alt = alt_in;
        r.ok      = !bad;
      end
    endcase
    return r;
  endfunction

  function automatic res_t decode_chunk(input chunk_t ch);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] fkey;
    logic [6:0] num;
    logic [6:0] code7;
    res_t       r;
    b0    = ch.bytes[0];
    b1    = ch.bytes[1];
    b2    = ch.bytes[2];
    b3    = ch.bytes[3];
    b4    = ch.bytes[4];
    fkey  = b3 - CHAR_A + 8'(KEY_F1);
    num   = 7'(b2[3:0]) * 7'd10 + 7'(b3[3:0]);
    code7 = 7'd0;
    r     = '0;
    if (b0 != BYTE_ESC) begin
      r = decode_single(ch, 1'b0, 1'b0);
    end else if (ch.n == 3'd1) begin
      r = give_named(KEY_ESC, 1'b0, 1'b0);
    end else if (ch.n == 3'd2) begin
      r = decode_single(ch, 1'b1, 1'b1);
    end else if (b1 != BYTE_LBRK) begin
      r = give_named(KEY_ESC, 1'b0, 1'b0);
    end else begin
      case (b2)
        CHAR_A: r = give_named(KEY_UP, 1'b0, 1'b0);
        CHAR_B: r = give_named(KEY_DOWN, 1'b0, 1'b0);
        CHAR_C: r = give_named(KEY_RIGHT, 1'b0, 1'b0);
        CHAR_D: r = give_named(KEY_LEFT, 1'b0, 1'b0);
        CHAR_F: r = give_named(KEY_END, 1'b0, 1'b0);
        CHAR_G: r = give_named(KEY_KP5, 1'b0, 1'b0);
        CHAR_H: r = give_named(KEY_HOME, 1'b0, 1'b0);
        BYTE_LBRK: begin
          if (ch.n >= 3'd4 && b3 >= CHAR_A && b3 <= CHAR_E) begin
            r = give_named(fkey[4:0], 1'b0, 1'b0);
          end
        end
        default: begin
          if (ch.n < 3'd4) begin
            r = '0;
          end else if (b3 == BYTE_TILDE) begin
            case (b2)
              CHAR_1:  r = give_named(KEY_HOME, 1'b0, 1'b0);
              CHAR_2:  r = give_named(KEY_INS, 1'b0, 1'b0);
              CHAR_3:  r = give_named(KEY_DEL, 1'b0, 1'b0);
              CHAR_4:  r = give_named(KEY_END, 1'b0, 1'b0);
              CHAR_5:  r = give_named(KEY_PGUP, 1'b0, 1'b0);
              CHAR_6:  r = give_named(KEY_PGDN, 1'b0, 1'b0);
              default: r = '0;
            endcase
          end else if (ch.n >= 3'd5 && b2 >= BYTE_ZERO && b2 <= BYTE_NINE &&
                       b3 >= BYTE_ZERO && b3 <= BYTE_NINE && b4 == BYTE_TILDE) begin
            // Two-digit function codes: f6-f12 plain, f1-f8 with shift.
            if (num >= 7'd17 && num <= 7'd21) begin
              code7 = num + 7'd4;
              r     = give_named(code7[4:0], 1'b0, 1'b0);
            end else if (num == 7'd23 || num == 7'd24) begin
              code7 = num + 7'd3;
              r     = give_named(code7[4:0], 1'b0, 1'b0);
            end else if (num == 7'd25 || num == 7'd26) begin
              code7 = num - 7'd9;
              r     = give_named(code7[4:0], 1'b1, 1'b0);
            end else if (num == 7'd28 || num == 7'd29) begin
              code7 = num - 7'd10;
              r     = give_named(code7[4:0], 1'b1, 1'b0);
            end else if (num >= 7'd31 && num <= 7'd34) begin
              code7 = num - 7'd11;
              r     = give_named(code7[4:0], 1'b1, 1'b0);
            end
          end
        end
      endcase
    end
    return r;
  endfunction

  res_t res;
  key_t key_r;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign res         = decode_chunk(chunk);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign chunk_ready = out_free;

  // A chunk that decodes to nothing is simply dropped here.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = chunk_valid && res.ok;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      key_r <= res.key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.is_named_key = key_r.is_named_key;
  assign out_ch.key_code     = key_r.key_code;
  assign out_ch.char_code    = key_r.char_code;
  assign out_ch.shift        = key_r.shift;
  assign out_ch.alt          = key_r.alt;
  assign out_ch.ctrl         = key_r.ctrl;

endmodule

/* hw/rtl/terminal_key_sequence_decoder.sv */
// Keyboard escape sequence decoder. Words of a keyboard chunk enter one per cycle on in_ch,
// the final word marked by last; the first five words of a chunk are kept and later ones are
// ignored. The key press for a chunk goes via the chunk snapshot, then the decoded result, to
// out_ch: a named key or a code point with shift, alt and ctrl flags. Chunks that form no known
// key give no output. A new word can be taken in every cycle; the rate is set by the two
// register stages (chunk snapshot, then decoded result), and the input only stalls while out_ch
// holds a result that has not been taken and a further chunk is already waiting to be decoded.
module terminal_key_sequence_decoder (
  input  logic       clk,
  input  logic       rst_n,
  tksd_in_if.sink    in_ch,
  tksd_out_if.source out_ch
);
  import tksd_pkg::*;

  logic   chunk_valid;
  logic   chunk_ready;
  chunk_t chunk;

  tksd_capture u_capture (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .chunk_ready (chunk_ready),
    .chunk_valid (chunk_valid),
    .chunk       (chunk)
  );

  tksd_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .chunk_valid (chunk_valid),
    .chunk       (chunk),
    .chunk_ready (chunk_ready),
    .out_ch      (out_ch)
  );

endmodule

/* tb/key_press_checker.sv */
`timescale 1ns / 1ps

module key_press_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  logic [7:0]     in_word,
  input  logic           in_last,
  input  logic           out_valid,
  input  logic           out_ready,
  input  tksd_pkg::key_t out_key,
  output int             mismatches,
  output int             pending
);
  import tksd_pkg::*;

  logic [7:0] chunk_bytes [StoreDepth];
  int         chunk_len;
  key_t       expected_keys [$];

  task automatic report(input string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [20:0] got, input logic [20:0] want);
    if (got !== want) begin
      report($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  function automatic key_t named_key(input logic [4:0] code, input logic shifted);
    key_t k;
    k = '0;
    k.is_named_key = 1'b1;
    k.key_code = code;
    k.shift = shifted;
    return k;
  endfunction

  // Decodes the single-byte forms starting at position pos of a chunk of n words.
  function automatic bit decode_single_byte(input int n, input int pos, input logic alt_flag,
                                            output key_t k);
    logic [7:0]  c;
    logic [7:0]  d;
    logic [20:0] cp;
    int          tail;
    c = chunk_bytes[pos];
    k = '0;
    if (c == BYTE_BS || c == BYTE_DEL) begin
      k = named_key(KEY_BKSP, 1'b0);
    end else if (c == BYTE_TAB) begin
      k = named_key(KEY_TAB, 1'b0);
    end else if (c == BYTE_CR) begin
      k = named_key(KEY_ENTER, 1'b0);
    end else if (c == BYTE_ESC) begin
      k = named_key(KEY_ESC, 1'b0);
    end else if (c >= 8'h01 && c <= BYTE_CTRLZ) begin
      k.char_code = {13'd0, c} + CTRL_OFFSET;
      k.ctrl = 1'b1;
    end else if (c[7]) begin
      // A UTF-8 lead byte says how many continuation bytes must follow.
      if (c[7:5] == 3'b110) begin
        tail = 1;
        cp = {16'd0, c[4:0]};
      end else if (c[7:4] == 4'b1110) begin
        tail = 2;
        cp = {17'd0, c[3:0]};
      end else if (c[7:3] == 5'b11110) begin
        tail = 3;
        cp = {18'd0, c[2:0]};
      end else begin
        return 1'b0;
      end
      if (n - pos - 1 < tail) return 1'b0;
      for (int i = 1; i <= tail; i++) begin
        d = chunk_bytes[pos + i];
        if (d[7:6] != 2'b10) return 1'b0;
        cp = {cp[14:0], d[5:0]};
      end
      k.char_code = cp;
    end else begin
      k.char_code = {13'd0, c};
    end
    k.alt = alt_flag;
    return 1'b1;
  endfunction

  function automatic bit predict_key_press(input int n, output key_t k);
    logic [7:0] c2;
    logic [7:0] c3;
    int         num;
    k = '0;
    if (chunk_bytes[0] != BYTE_ESC) return decode_single_byte(n, 0, 1'b0, k);
    if (n == 1) begin
      k = named_key(KEY_ESC, 1'b0);
      return 1'b1;
    end
    if (n == 2) return decode_single_byte(n, 1, 1'b1, k);
    if (chunk_bytes[1] != BYTE_LBRK) begin
      k = named_key(KEY_ESC, 1'b0);
      return 1'b1;
    end
    c2 = chunk_bytes[2];
    case (c2)
      CHAR_A: k = named_key(KEY_UP, 1'b0);
      CHAR_B: k = named_key(KEY_DOWN, 1'b0);
      CHAR_C: k = named_key(KEY_RIGHT, 1'b0);
      CHAR_D: k = named_key(KEY_LEFT, 1'b0);
      CHAR_F: k = named_key(KEY_END, 1'b0);
      CHAR_G: k = named_key(KEY_KP5, 1'b0);
      CHAR_H: k = named_key(KEY_HOME, 1'b0);
      BYTE_LBRK: begin
        if (n >= 4 && chunk_bytes[3] >= CHAR_A && chunk_bytes[3] <= CHAR_E) begin
          k = named_key(KEY_F1 + 5'(chunk_bytes[3] - CHAR_A), 1'b0);
        end
      end
      default: ;
    endcase
    if (k.is_named_key || c2 == BYTE_LBRK) return k.is_named_key;
    if (n < 4) return 1'b0;
    c3 = chunk_bytes[3];
    if (c3 == BYTE_TILDE) begin
      case (c2)
        CHAR_1: k = named_key(KEY_HOME, 1'b0);
        CHAR_2: k = named_key(KEY_INS, 1'b0);
        CHAR_3: k = named_key(KEY_DEL, 1'b0);
        CHAR_4: k = named_key(KEY_END, 1'b0);
        CHAR_5: k = named_key(KEY_PGUP, 1'b0);
        CHAR_6: k = named_key(KEY_PGDN, 1'b0);
        default: ;
      endcase
      return k.is_named_key;
    end
    if (n < 5) return 1'b0;
    if (c2 < BYTE_ZERO || c2 > BYTE_NINE || c3 < BYTE_ZERO || c3 > BYTE_NINE ||
        chunk_bytes[4] != BYTE_TILDE) return 1'b0;
    // Two-digit codes give f6 to f12 plain, then f1 to f8 with shift.
    num = int'(c2 - BYTE_ZERO) * 10 + int'(c3 - BYTE_ZERO);
    if (num >= 17 && num <= 21) k = named_key(KEY_F1 + 5'(num - 12), 1'b0);
    else if (num == 23 || num == 24) k = named_key(KEY_F1 + 5'(num - 13), 1'b0);
    else if (num == 25 || num == 26) k = named_key(KEY_F1 + 5'(num - 25), 1'b1);
    else if (num == 28 || num == 29) k = named_key(KEY_F1 + 5'(num - 26), 1'b1);
    else if (num >= 31 && num <= 34) k = named_key(KEY_F1 + 5'(num - 27), 1'b1);
    return k.is_named_key;
  endfunction

  always @(posedge clk) begin
    key_t want;
    if (!rst_n) begin
      chunk_len = 0;
      expected_keys.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_keys.size() == 0) begin
          report($sformatf("key press %0h arrived with none expected", out_key));
        end else begin
          want = expected_keys.pop_front();
          check_field("is_named_key", 21'(out_key.is_named_key), 21'(want.is_named_key));
          check_field("key_code", 21'(out_key.key_code), 21'(want.key_code));
          check_field("char_code", out_key.char_code, want.char_code);
          check_field("shift", 21'(out_key.shift), 21'(want.shift));
          check_field("alt", 21'(out_key.alt), 21'(want.alt));
          check_field("ctrl", 21'(out_key.ctrl), 21'(want.ctrl));
        end
      end
      if (in_valid && in_ready) begin
        if (chunk_len < StoreDepth) begin
          chunk_bytes[chunk_len] = in_word;
          chunk_len++;
        end
        if (in_last) begin
          if (predict_key_press(chunk_len, want)) expected_keys = {expected_keys, want};
          chunk_len = 0;
        end
      end
    end
    pending = expected_keys.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import tksd_pkg::*;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   pending;
  int   idle_pct;
  int   words_sent;
  int   drain_cycles;
  logic [7:0] chunk_words [$];

  tksd_in_if  in_ch ();
  tksd_out_if out_ch ();

  terminal_key_sequence_decoder DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  key_press_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_word    (in_ch.byte_req),
    .in_last    (in_ch.last),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_key    ({out_ch.is_named_key, out_ch.key_code, out_ch.char_code,
                  out_ch.shift, out_ch.alt, out_ch.ctrl}),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

  // The receiver stalls in bursts whose frequency follows the current idle level.
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        stall = $urandom_range(0, 7);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic [7:0] word_val, input logic is_last);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.byte_req <= word_val;
    in_ch.last <= is_last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic send_chunk();
    foreach (chunk_words[i]) send_word(chunk_words[i], i == chunk_words.size() - 1);
  endtask

  task automatic append_word(input logic [7:0] word_val);
    chunk_words = {chunk_words, word_val};
  endtask

  task automatic push_utf8();
    int tail;
    tail = $urandom_range(1, 3);
    case (tail)
      1: append_word(8'(8'hc0 | $urandom_range(0, 31)));
      2: append_word(8'(8'he0 | $urandom_range(0, 15)));
      default: append_word(8'(8'hf0 | $urandom_range(0, 7)));
    endcase
    for (int i = 0; i < tail; i++) append_word(8'(8'h80 | $urandom_range(0, 63)));
    // Now and then a bad continuation byte or a missing one.
    if ($urandom_range(0, 7) == 0) begin
      chunk_words[$urandom_range(1, tail)] = 8'($urandom_range(0, 255));
    end else if ($urandom_range(0, 7) == 0) begin
      void'(chunk_words.pop_back());
    end
  endtask

  task automatic build_random_chunk();
    int num;
    chunk_words.delete();
    case ($urandom_range(0, 12))
      0: append_word(8'($urandom_range(0, 255)));
      1: append_word(8'($urandom_range(0, 31)));
      2: append_word(BYTE_ESC);
      3: chunk_words = '{BYTE_ESC, 8'($urandom_range(0, 255))};
      4: chunk_words = '{BYTE_ESC, BYTE_LBRK, 8'(CHAR_A + $urandom_range(0, 7))};
      5: begin
        chunk_words = '{BYTE_ESC, BYTE_LBRK, BYTE_LBRK};
        if ($urandom_range(0, 5) != 0) append_word(8'(CHAR_A + $urandom_range(0, 5)));
      end
      6: chunk_words = '{BYTE_ESC, BYTE_LBRK, 8'(BYTE_ZERO + $urandom_range(0, 9)), BYTE_TILDE};
      7, 8: begin
        num = ($urandom_range(0, 3) != 0) ? $urandom_range(10, 39) : $urandom_range(0, 99);
        chunk_words = '{BYTE_ESC, BYTE_LBRK, 8'(BYTE_ZERO + num / 10),
                        8'(BYTE_ZERO + num % 10), BYTE_TILDE};
        if ($urandom_range(0, 7) == 0) begin
          chunk_words[$urandom_range(2, 4)] = 8'($urandom_range(0, 255));
        end
      end
      9, 10: push_utf8();
      11: begin
        if ($urandom_range(0, 1) == 0) append_word(BYTE_ESC);
        repeat ($urandom_range(1, 7)) append_word(8'($urandom_range(0, 255)));
      end
      default: begin
        chunk_words = '{BYTE_ESC, 8'($urandom_range(0, 255))};
        repeat ($urandom_range(1, 4)) append_word(8'($urandom_range(0, 255)));
      end
    endcase
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) append_word(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.byte_req = 8'h00;
    in_ch.last = 1'b0;
    idle_pct = 20;
    words_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    chunk_words = '{8'h00};                               send_chunk();
    chunk_words = '{8'hff};                               send_chunk();
    chunk_words = '{BYTE_ESC};                            send_chunk();
    chunk_words = '{BYTE_ESC, 8'h61};                     send_chunk();
    chunk_words = '{BYTE_ESC, BYTE_CTRLZ};                send_chunk();
    chunk_words = '{BYTE_ESC, 8'hc3};                     send_chunk();
    chunk_words = '{BYTE_ESC, 8'h78, 8'h79};              send_chunk();
    chunk_words = '{BYTE_ESC, BYTE_LBRK, CHAR_A};         send_chunk();
    chunk_words = '{BYTE_ESC, BYTE_LBRK, BYTE_LBRK, CHAR_E};  send_chunk();
    chunk_words = '{BYTE_ESC, BYTE_LBRK, CHAR_3, BYTE_TILDE}; send_chunk();
    chunk_words = '{BYTE_ESC, BYTE_LBRK, CHAR_2, CHAR_4, BYTE_TILDE}; send_chunk();
    // A long chunk: the words after the fifth must be ignored.
    chunk_words = '{BYTE_ESC, BYTE_LBRK, CHAR_3, CHAR_4, BYTE_TILDE, 8'h7a, 8'h71};
    send_chunk();
    chunk_words = '{8'hf4, 8'h8f, 8'hbf, 8'hbf};          send_chunk();
    chunk_words = '{8'he2, 8'h82};                        send_chunk();
    chunk_words = '{BYTE_DEL};                            send_chunk();
    chunk_words = '{BYTE_CR};                             send_chunk();
    chunk_words = '{BYTE_TAB};                            send_chunk();
    chunk_words = '{BYTE_BS};                             send_chunk();
    chunk_words = '{BYTE_TILDE};                          send_chunk();

    while (words_sent < 2000) begin
      if (words_sent >= 1700) begin
        idle_pct = 0;
      end else if ($urandom_range(0, 39) == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 15;
          default: idle_pct = 40;
        endcase
      end
      build_random_chunk();
      send_chunk();
    end
    in_ch.valid <= 1'b0;

    drain_cycles = 0;
    while (pending != 0 && drain_cycles < 1000) begin
      @(negedge clk);
      drain_cycles++;
    end
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
